### design/perspective_coordinate_map_unit_assert.svh
// Assertion macros shared by the perspective coordinate map checker
`ifndef PERSPECTIVE_COORDINATE_MAP_UNIT_ASSERT_SVH
`define PERSPECTIVE_COORDINATE_MAP_UNIT_ASSERT_SVH

// same-cycle implication, masked while reset is high
`define PCM_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pcm: same-cycle check failed");

// next-cycle implication, masked while reset is high
`define PCM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pcm: next-cycle check failed");

// implication that also holds through reset
`define PCM_ASSERT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("pcm: reset check failed");

`endif

### design/pcm_pkg.sv
// Shared constants, word types and codes for the perspective coordinate map
package pcm_pkg;

   localparam int COORD_WIDTH     = 16;
   localparam int FRAC_BITS       = 16;
   localparam int COEF_WIDTH      = 32;
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int PROD_WIDTH      = 2 * COEF_WIDTH;
   localparam int K_WIDTH         = 2 * COEF_WIDTH + 2;
   localparam int SPLIT_BITS      = K_WIDTH / 2;
   localparam int WIDE_WIDTH      = K_WIDTH + COORD_WIDTH + 6;
   localparam int DIV_WIDTH       = WIDE_WIDTH + COORD_WIDTH;
   localparam int FWD_ARG_WIDTH   = COORD_WIDTH + 1;
   localparam int FWD_PROD_WIDTH  = COEF_WIDTH + FWD_ARG_WIDTH;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam int REFRESH_WIDTH   = 2;
   localparam logic [REFRESH_WIDTH-1:0] REFRESH_CYCLES = 2'd2;

   localparam logic signed [COEF_WIDTH-1:0] COEF_A_RESET = 32'sd711289;
   localparam logic signed [COEF_WIDTH-1:0] COEF_B_RESET = 32'sd1769472;
   localparam logic signed [COEF_WIDTH-1:0] COEF_C_RESET = -32'sd27759162;
   localparam logic signed [COEF_WIDTH-1:0] COEF_D_RESET = 32'sd65536;
   localparam logic signed [COEF_WIDTH-1:0] COEF_E_RESET = 32'sd2017178;
   localparam logic signed [COEF_WIDTH-1:0] COEF_F_RESET = -32'sd16462296;
   localparam logic signed [COEF_WIDTH-1:0] COEF_G_RESET = 32'sd0;
   localparam logic signed [COEF_WIDTH-1:0] COEF_H_RESET = 32'sd45686;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_COEF_A = 4'd0,
      CSR_COEF_B = 4'd1,
      CSR_COEF_C = 4'd2,
      CSR_COEF_D = 4'd3,
      CSR_COEF_E = 4'd4,
      CSR_COEF_F = 4'd5,
      CSR_COEF_G = 4'd6,
      CSR_COEF_H = 4'd7
   } csr_index_type;

   typedef enum logic {
      CMD_FORWARD = 1'b0,
      CMD_REVERSE = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type                       command;
      logic signed [COORD_WIDTH-1:0] coord_row;
      logic signed [COORD_WIDTH-1:0] coord_col;
   } req_word_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] result_x;
      logic signed [COORD_WIDTH-1:0] result_y;
      logic                          zero_divisor;
   } rsp_word_type;

   typedef struct packed {
      logic signed [COEF_WIDTH-1:0] coef_a;
      logic signed [COEF_WIDTH-1:0] coef_b;
      logic signed [COEF_WIDTH-1:0] coef_c;
      logic signed [COEF_WIDTH-1:0] coef_d;
      logic signed [COEF_WIDTH-1:0] coef_e;
      logic signed [COEF_WIDTH-1:0] coef_f;
      logic signed [COEF_WIDTH-1:0] coef_g;
      logic signed [COEF_WIDTH-1:0] coef_h;
   } coef_set_type;

   // coefficient-only terms of the closed-form inverse
   typedef struct packed {
      logic signed [K_WIDTH-1:0] k_det0;
      logic signed [K_WIDTH-1:0] k_det_y;
      logic signed [K_WIDTH-1:0] k_det_x;
      logic signed [K_WIDTH-1:0] k_u0;
      logic signed [K_WIDTH-1:0] k_u_y;
      logic signed [K_WIDTH-1:0] k_u_x;
      logic signed [K_WIDTH-1:0] k_v0;
      logic signed [K_WIDTH-1:0] k_v_y;
      logic signed [K_WIDTH-1:0] k_v_x;
   } derived_type;

   typedef struct packed {
      logic signed [WIDE_WIDTH-1:0] num_x;
      logic signed [WIDE_WIDTH-1:0] num_y;
      logic signed [WIDE_WIDTH-1:0] den;
      logic                         round_half;
      logic                         zero_den;
   } div_job_type;

   typedef struct packed {
      logic empty;
      logic almost_full;
   } queue_status_type;

endpackage

### design/pcm_coef.sv
// Coefficient registers and derived inverse terms
module pcm_coef (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pcm_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [pcm_pkg::COEF_WIDTH-1:0]       csr_data,
   output pcm_pkg::coef_set_type                coefs,
   output pcm_pkg::derived_type                 derived,
   output logic                                 refresh_busy
);

   localparam int PW = pcm_pkg::PROD_WIDTH;
   localparam int KW = pcm_pkg::K_WIDTH;
   localparam int FB = pcm_pkg::FRAC_BITS;

   pcm_pkg::coef_set_type coef_ff, coef_in;
   pcm_pkg::derived_type  derived_ff, derived_in;
   logic [pcm_pkg::REFRESH_WIDTH-1:0] refresh_ff, refresh_in;
   logic wr;

   logic signed [PW-1:0] p_ae_in, p_bd_in, p_dh_in, p_eg_in, p_bg_in, p_ah_in, p_bf_in;
   logic signed [PW-1:0] p_ce_in, p_fh_in, p_ch_in, p_af_in, p_cd_in, p_fg_in, p_cg_in;
   logic signed [PW-1:0] p_ae_ff, p_bd_ff, p_dh_ff, p_eg_ff, p_bg_ff, p_ah_ff, p_bf_ff;
   logic signed [PW-1:0] p_ce_ff, p_fh_ff, p_ch_ff, p_af_ff, p_cd_ff, p_fg_ff, p_cg_ff;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid && csr_ready;

   always_comb begin
      coef_in = coef_ff;
      if (wr) begin
         case (pcm_pkg::csr_index_type'(csr_index))
            pcm_pkg::CSR_COEF_A: coef_in.coef_a = csr_data;
            pcm_pkg::CSR_COEF_B: coef_in.coef_b = csr_data;
            pcm_pkg::CSR_COEF_C: coef_in.coef_c = csr_data;
            pcm_pkg::CSR_COEF_D: coef_in.coef_d = csr_data;
            pcm_pkg::CSR_COEF_E: coef_in.coef_e = csr_data;
            pcm_pkg::CSR_COEF_F: coef_in.coef_f = csr_data;
            pcm_pkg::CSR_COEF_G: coef_in.coef_g = csr_data;
            pcm_pkg::CSR_COEF_H: coef_in.coef_h = csr_data;
            default: ;
         endcase
      end
   end

   // any write restarts the two-stage refresh of the derived terms
   always_comb begin
      if (wr) begin
         refresh_in = pcm_pkg::REFRESH_CYCLES;
      end else if (refresh_ff != '0) begin
         refresh_in = refresh_ff - 1'b1;
      end else begin
         refresh_in = refresh_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.coef_a <= pcm_pkg::COEF_A_RESET;
         coef_ff.coef_b <= pcm_pkg::COEF_B_RESET;
         coef_ff.coef_c <= pcm_pkg::COEF_C_RESET;
         coef_ff.coef_d <= pcm_pkg::COEF_D_RESET;
         coef_ff.coef_e <= pcm_pkg::COEF_E_RESET;
         coef_ff.coef_f <= pcm_pkg::COEF_F_RESET;
         coef_ff.coef_g <= pcm_pkg::COEF_G_RESET;
         coef_ff.coef_h <= pcm_pkg::COEF_H_RESET;
         refresh_ff     <= pcm_pkg::REFRESH_CYCLES;
      end else begin
         coef_ff    <= coef_in;
         refresh_ff <= refresh_in;
      end
   end

   assign p_ae_in = coef_ff.coef_a * coef_ff.coef_e;
   assign p_bd_in = coef_ff.coef_b * coef_ff.coef_d;
   assign p_dh_in = coef_ff.coef_d * coef_ff.coef_h;
   assign p_eg_in = coef_ff.coef_e * coef_ff.coef_g;
   assign p_bg_in = coef_ff.coef_b * coef_ff.coef_g;
   assign p_ah_in = coef_ff.coef_a * coef_ff.coef_h;
   assign p_bf_in = coef_ff.coef_b * coef_ff.coef_f;
   assign p_ce_in = coef_ff.coef_c * coef_ff.coef_e;
   assign p_fh_in = coef_ff.coef_f * coef_ff.coef_h;
   assign p_ch_in = coef_ff.coef_c * coef_ff.coef_h;
   assign p_af_in = coef_ff.coef_a * coef_ff.coef_f;
   assign p_cd_in = coef_ff.coef_c * coef_ff.coef_d;
   assign p_fg_in = coef_ff.coef_f * coef_ff.coef_g;
   assign p_cg_in = coef_ff.coef_c * coef_ff.coef_g;

   always_ff @(posedge clock) begin
      p_ae_ff <= p_ae_in;
      p_bd_ff <= p_bd_in;
      p_dh_ff <= p_dh_in;
      p_eg_ff <= p_eg_in;
      p_bg_ff <= p_bg_in;
      p_ah_ff <= p_ah_in;
      p_bf_ff <= p_bf_in;
      p_ce_ff <= p_ce_in;
      p_fh_ff <= p_fh_in;
      p_ch_ff <= p_ch_in;
      p_af_ff <= p_af_in;
      p_cd_ff <= p_cd_in;
      p_fg_ff <= p_fg_in;
      p_cg_ff <= p_cg_in;
   end

   always_comb begin
      derived_in.k_det0  = KW'(p_ae_ff) - KW'(p_bd_ff);
      derived_in.k_det_y = KW'(p_dh_ff) - KW'(p_eg_ff);
      derived_in.k_det_x = KW'(p_bg_ff) - KW'(p_ah_ff);
      derived_in.k_u0    = KW'(p_bf_ff) - KW'(p_ce_ff);
      derived_in.k_u_y   = (KW'(coef_ff.coef_e) <<< FB) - KW'(p_fh_ff);
      derived_in.k_u_x   = KW'(p_ch_ff) - (KW'(coef_ff.coef_b) <<< FB);
      derived_in.k_v0    = KW'(p_af_ff) - KW'(p_cd_ff);
      derived_in.k_v_y   = (KW'(coef_ff.coef_d) <<< FB) - KW'(p_fg_ff);
      derived_in.k_v_x   = KW'(p_cg_ff) - (KW'(coef_ff.coef_a) <<< FB);
   end

   always_ff @(posedge clock) begin
      derived_ff <= derived_in;
   end

   assign coefs        = coef_ff;
   assign derived      = derived_ff;
   assign refresh_busy = (refresh_ff != '0);

endmodule

### design/pcm_queue.sv
// Short job queue between the front end and the divider
module pcm_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  pcm_pkg::div_job_type       push_job,
   input  logic                       pop,
   output logic                       head_valid,
   output pcm_pkg::div_job_type       head_job,
   output pcm_pkg::queue_status_type  status
);

   pcm_pkg::div_job_type mem [pcm_pkg::QUEUE_DEPTH];
   pcm_pkg::div_job_type head_ff;
   logic head_valid_ff, head_valid_in;
   logic [pcm_pkg::QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [pcm_pkg::QUEUE_CNT_WIDTH-1:0] count_ff, count_in;
   logic do_pop;

   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in     = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in     = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in      = count_ff + (push ? 1'b1 : 1'b0) - (do_pop ? 1'b1 : 1'b0);
      head_valid_in = do_pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
         head_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
         head_valid_ff <= head_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_job;
      end
      if (do_pop) begin
         head_ff <= mem[rd_ptr_ff];
      end
   end

   assign head_valid         = head_valid_ff;
   assign head_job           = head_ff;
   assign status.empty       = (count_ff == '0);
   assign status.almost_full = (count_ff >= pcm_pkg::QUEUE_CNT_WIDTH'(pcm_pkg::QUEUE_DEPTH - 1));

endmodule

### design/pcm_front.sv
// Front end: forms numerators and denominator for both directions
module pcm_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  pcm_pkg::req_word_type  req_word,
   input  pcm_pkg::coef_set_type  coefs,
   input  pcm_pkg::derived_type   derived,
   output logic                   push,
   output pcm_pkg::div_job_type   push_job
);

   localparam int CW    = pcm_pkg::COORD_WIDTH;
   localparam int KW    = pcm_pkg::K_WIDTH;
   localparam int SB    = pcm_pkg::SPLIT_BITS;
   localparam int WW    = pcm_pkg::WIDE_WIDTH;
   localparam int AW    = pcm_pkg::FWD_ARG_WIDTH;
   localparam int FPW   = pcm_pkg::FWD_PROD_WIDTH;
   localparam int NTERM = 6;
   localparam int LOW   = SB + 1 + CW;
   localparam int HIW   = KW - SB + CW;
   localparam logic signed [WW-1:0] FIX_ONE = WW'(1) <<< pcm_pkg::FRAC_BITS;

   // stage 1: captured command word
   logic s1_valid_ff;
   pcm_pkg::req_word_type s1_req_ff;
   logic signed [AW-1:0] arg_r, arg_c;

   // stage 2: products
   logic s2_valid_ff;
   pcm_pkg::cmd_type s2_cmd_ff;
   logic signed [FPW-1:0] m_ac_in, m_br_in, m_dc_in, m_er_in, m_gc_in, m_hr_in;
   logic signed [FPW-1:0] m_ac_ff, m_br_ff, m_dc_ff, m_er_ff, m_gc_ff, m_hr_ff;
   logic signed [KW-1:0]  k_sel [NTERM];
   logic signed [CW-1:0]  w_sel [NTERM];
   logic signed [LOW-1:0] lo_in [NTERM];
   logic signed [HIW-1:0] hi_in [NTERM];
   logic signed [LOW-1:0] lo_ff [NTERM];
   logic signed [HIW-1:0] hi_ff [NTERM];

   // stage 3: recombined terms
   logic s3_valid_ff;
   pcm_pkg::cmd_type s3_cmd_ff;
   logic signed [WW-1:0] term_in [NTERM];
   logic signed [WW-1:0] term_ff [NTERM];
   logic signed [WW-1:0] f_y_in, f_x_in, f_d_in, f_y_ff, f_x_ff, f_d_ff;

   // stage 4: full sums per direction
   logic s4_valid_ff;
   pcm_pkg::cmd_type s4_cmd_ff;
   logic signed [WW-1:0] s4_a_in, s4_b_in, s4_den_in, s4_a_ff, s4_b_ff, s4_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff <= req_word;
      end
   end

   // forward mode works on one-based image coordinates
   assign arg_r = AW'(s1_req_ff.coord_row) + AW'(1);
   assign arg_c = AW'(s1_req_ff.coord_col) + AW'(1);

   assign m_ac_in = coefs.coef_a * arg_c;
   assign m_br_in = coefs.coef_b * arg_r;
   assign m_dc_in = coefs.coef_d * arg_c;
   assign m_er_in = coefs.coef_e * arg_r;
   assign m_gc_in = coefs.coef_g * arg_c;
   assign m_hr_in = coefs.coef_h * arg_r;

   // reverse: world row is X, world column is Y
   assign k_sel[0] = derived.k_det_y;  assign w_sel[0] = s1_req_ff.coord_col;
   assign k_sel[1] = derived.k_det_x;  assign w_sel[1] = s1_req_ff.coord_row;
   assign k_sel[2] = derived.k_u_y;    assign w_sel[2] = s1_req_ff.coord_col;
   assign k_sel[3] = derived.k_u_x;    assign w_sel[3] = s1_req_ff.coord_row;
   assign k_sel[4] = derived.k_v_y;    assign w_sel[4] = s1_req_ff.coord_col;
   assign k_sel[5] = derived.k_v_x;    assign w_sel[5] = s1_req_ff.coord_row;

   // wide term split into two halves so each multiplier stays narrow
   always_comb begin
      for (int t = 0; t < NTERM; t++) begin
         lo_in[t] = $signed({1'b0, k_sel[t][SB-1:0]}) * w_sel[t];
         hi_in[t] = $signed(k_sel[t][KW-1:SB]) * w_sel[t];
      end
   end

   always_ff @(posedge clock) begin
      s2_cmd_ff <= s1_req_ff.command;
      m_ac_ff   <= m_ac_in;
      m_br_ff   <= m_br_in;
      m_dc_ff   <= m_dc_in;
      m_er_ff   <= m_er_in;
      m_gc_ff   <= m_gc_in;
      m_hr_ff   <= m_hr_in;
      for (int t = 0; t < NTERM; t++) begin
         lo_ff[t] <= lo_in[t];
         hi_ff[t] <= hi_in[t];
      end
   end

   always_comb begin
      for (int t = 0; t < NTERM; t++) begin
         term_in[t] = (WW'(hi_ff[t]) <<< SB) + WW'(lo_ff[t]);
      end
      f_y_in = WW'(m_ac_ff) + WW'(m_br_ff);
      f_x_in = WW'(m_dc_ff) + WW'(m_er_ff);
      f_d_in = WW'(m_gc_ff) + WW'(m_hr_ff);
   end

   always_ff @(posedge clock) begin
      s3_cmd_ff <= s2_cmd_ff;
      f_y_ff    <= f_y_in;
      f_x_ff    <= f_x_in;
      f_d_ff    <= f_d_in;
      for (int t = 0; t < NTERM; t++) begin
         term_ff[t] <= term_in[t];
      end
   end

   // a carries the y numerator, b the x numerator (negated in reverse)
   always_comb begin
      if (s3_cmd_ff == pcm_pkg::CMD_REVERSE) begin
         s4_den_in = WW'(derived.k_det0) + term_ff[0] + term_ff[1];
         s4_a_in   = WW'(derived.k_u0) + term_ff[2] + term_ff[3];
         s4_b_in   = WW'(derived.k_v0) + term_ff[4] + term_ff[5];
      end else begin
         s4_den_in = f_d_ff + FIX_ONE;
         s4_a_in   = f_y_ff + WW'(coefs.coef_c);
         s4_b_in   = f_x_ff + WW'(coefs.coef_f);
      end
   end

   always_ff @(posedge clock) begin
      s4_cmd_ff <= s3_cmd_ff;
      s4_a_ff   <= s4_a_in;
      s4_b_ff   <= s4_b_in;
      s4_den_ff <= s4_den_in;
   end

   // reverse results carry the minus-one offset as a subtracted denominator
   always_comb begin
      push_job.den        = s4_den_ff;
      push_job.round_half = (s4_cmd_ff == pcm_pkg::CMD_REVERSE);
      push_job.zero_den   = (s4_den_ff == '0);
      if (s4_cmd_ff == pcm_pkg::CMD_REVERSE) begin
         push_job.num_x = -s4_b_ff - s4_den_ff;
         push_job.num_y = s4_a_ff - s4_den_ff;
      end else begin
         push_job.num_x = s4_b_ff;
         push_job.num_y = s4_a_ff;
      end
   end

   assign push = s4_valid_ff;

endmodule

### design/pcm_div.sv
// Back end: pipelined restoring divider with rounding and saturation
module pcm_div (
   input  logic                       clock,
   input  logic                       reset,
   input  pcm_pkg::queue_status_type  q_status,
   input  logic                       head_valid,
   input  pcm_pkg::div_job_type       head_job,
   output logic                       pop,
   output logic                       rsp_valid,
   output pcm_pkg::rsp_word_type      rsp_word
);

   localparam int WW = pcm_pkg::WIDE_WIDTH;
   localparam int DW = pcm_pkg::DIV_WIDTH;
   localparam int QB = pcm_pkg::COORD_WIDTH;

   typedef struct packed {
      logic valid;
      logic zero;
      logic round;
      logic neg_x;
      logic neg_y;
      logic ovf_x;
      logic ovf_y;
   } div_ctl_type;

   // stage 1: magnitudes and signs
   div_ctl_type d1_ctl_ff, d1_ctl_in;
   logic [WW-1:0] d1_nx_ff, d1_ny_ff, d1_d_ff, d1_nx_in, d1_ny_in, d1_d_in;

   // stage 2: rounding offset applied
   div_ctl_type d2_ctl_ff;
   logic [DW-1:0] d2_nx_ff, d2_ny_ff, d2_d_ff, d2_nx_in, d2_ny_in, d2_d_in;

   // division steps; index 0 holds the range check
   div_ctl_type   st_ctl_ff  [QB+1];
   logic [DW-1:0] st_rx_ff   [QB+1];
   logic [DW-1:0] st_ry_ff   [QB+1];
   logic [DW-1:0] st_d_ff    [QB+1];
   logic [QB-1:0] st_qx_ff   [QB+1];
   logic [QB-1:0] st_qy_ff   [QB+1];
   logic [DW-1:0] st_rx_in   [QB];
   logic [DW-1:0] st_ry_in   [QB];
   logic [QB-1:0] st_qx_in   [QB];
   logic [QB-1:0] st_qy_in   [QB];
   div_ctl_type   st0_ctl_in;

   pcm_pkg::rsp_word_type rsp_word_ff, rsp_word_in;
   logic rsp_valid_ff;

   function automatic logic [QB-1:0] sat_fn(input logic [QB-1:0] q, input logic neg,
                                            input logic ovf);
      logic [QB-1:0] lim;
      logic [QB-1:0] mag;
      lim = neg ? (QB'(1) << (QB - 1)) : ((QB'(1) << (QB - 1)) - QB'(1));
      mag = (ovf || (q > lim)) ? lim : q;
      return neg ? -mag : mag;
   endfunction

   assign pop = !q_status.empty;

   always_comb begin
      d1_ctl_in       = '0;
      d1_ctl_in.valid = head_valid;
      d1_ctl_in.zero  = head_job.zero_den;
      d1_ctl_in.round = head_job.round_half;
      d1_ctl_in.neg_x = head_job.num_x[WW-1] ^ head_job.den[WW-1];
      d1_ctl_in.neg_y = head_job.num_y[WW-1] ^ head_job.den[WW-1];
      d1_nx_in = head_job.num_x[WW-1] ? $unsigned(-head_job.num_x) : $unsigned(head_job.num_x);
      d1_ny_in = head_job.num_y[WW-1] ? $unsigned(-head_job.num_y) : $unsigned(head_job.num_y);
      d1_d_in  = head_job.den[WW-1] ? $unsigned(-head_job.den) : $unsigned(head_job.den);
   end

   // half away from zero: (2n + d) / 2d
   always_comb begin
      if (d1_ctl_ff.round) begin
         d2_nx_in = (DW'(d1_nx_ff) << 1) + DW'(d1_d_ff);
         d2_ny_in = (DW'(d1_ny_ff) << 1) + DW'(d1_d_ff);
         d2_d_in  = DW'(d1_d_ff) << 1;
      end else begin
         d2_nx_in = DW'(d1_nx_ff);
         d2_ny_in = DW'(d1_ny_ff);
         d2_d_in  = DW'(d1_d_ff);
      end
   end

   always_comb begin
      st0_ctl_in       = d2_ctl_ff;
      st0_ctl_in.ovf_x = (d2_nx_ff >= (d2_d_ff << QB));
      st0_ctl_in.ovf_y = (d2_ny_ff >= (d2_d_ff << QB));
   end

   always_comb begin
      for (int s = 0; s < QB; s++) begin
         if (st_rx_ff[s] >= (st_d_ff[s] << (QB - 1 - s))) begin
            st_rx_in[s] = st_rx_ff[s] - (st_d_ff[s] << (QB - 1 - s));
            st_qx_in[s] = {st_qx_ff[s][QB-2:0], 1'b1};
         end else begin
            st_rx_in[s] = st_rx_ff[s];
            st_qx_in[s] = {st_qx_ff[s][QB-2:0], 1'b0};
         end
         if (st_ry_ff[s] >= (st_d_ff[s] << (QB - 1 - s))) begin
            st_ry_in[s] = st_ry_ff[s] - (st_d_ff[s] << (QB - 1 - s));
            st_qy_in[s] = {st_qy_ff[s][QB-2:0], 1'b1};
         end else begin
            st_ry_in[s] = st_ry_ff[s];
            st_qy_in[s] = {st_qy_ff[s][QB-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      if (st_ctl_ff[QB].zero) begin
         rsp_word_in.result_x     = '0;
         rsp_word_in.result_y     = '0;
         rsp_word_in.zero_divisor = 1'b1;
      end else begin
         rsp_word_in.result_x = sat_fn(st_qx_ff[QB], st_ctl_ff[QB].neg_x, st_ctl_ff[QB].ovf_x);
         rsp_word_in.result_y = sat_fn(st_qy_ff[QB], st_ctl_ff[QB].neg_y, st_ctl_ff[QB].ovf_y);
         rsp_word_in.zero_divisor = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_ctl_ff    <= '0;
         d2_ctl_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s <= QB; s++) begin
            st_ctl_ff[s] <= '0;
         end
      end else begin
         d1_ctl_ff    <= d1_ctl_in;
         d2_ctl_ff    <= d1_ctl_ff;
         st_ctl_ff[0] <= st0_ctl_in;
         for (int s = 0; s < QB; s++) begin
            st_ctl_ff[s+1] <= st_ctl_ff[s];
         end
         rsp_valid_ff <= st_ctl_ff[QB].valid;
      end
   end

   always_ff @(posedge clock) begin
      d1_nx_ff    <= d1_nx_in;
      d1_ny_ff    <= d1_ny_in;
      d1_d_ff     <= d1_d_in;
      d2_nx_ff    <= d2_nx_in;
      d2_ny_ff    <= d2_ny_in;
      d2_d_ff     <= d2_d_in;
      st_rx_ff[0] <= d2_nx_ff;
      st_ry_ff[0] <= d2_ny_ff;
      st_d_ff[0]  <= d2_d_ff;
      st_qx_ff[0] <= '0;
      st_qy_ff[0] <= '0;
      for (int s = 0; s < QB; s++) begin
         st_rx_ff[s+1] <= st_rx_in[s];
         st_ry_ff[s+1] <= st_ry_in[s];
         st_d_ff[s+1]  <= st_d_ff[s];
         st_qx_ff[s+1] <= st_qx_in[s];
         st_qy_ff[s+1] <= st_qy_in[s];
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

### design/perspective_coordinate_map_unit.sv
// Top level of the perspective coordinate map unit
//
//   channel   ports                          direction  handshake
//   command   start, busy, req_word          in         start & !busy
//   result    rsp_valid, rsp_word            out        one-cycle strobe
//   csr       csr_valid, csr_ready,          in         valid & ready
//             csr_index, csr_data
//
// One command word per clock while busy is low. Each result word passes through
// 4 front stages, the queue entry and its read register, and 20 divider stages
// (sign, rounding, range check, 16 restoring steps for both quotients side by
// side, output register).
// After reset, and after every csr write, busy stays high while the product
// and derived-term registers refresh the derived inverse terms.
// Reset is synchronous and active high; it empties the pipe and the queue.
// The result side cannot stall, so the queue never holds more than one word.
module perspective_coordinate_map_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  pcm_pkg::req_word_type                req_word,
   output logic                                 rsp_valid,
   output pcm_pkg::rsp_word_type                rsp_word,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pcm_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [pcm_pkg::COEF_WIDTH-1:0]       csr_data
);

   pcm_pkg::coef_set_type     coefs;
   pcm_pkg::derived_type      derived;
   pcm_pkg::div_job_type      push_job, head_job;
   pcm_pkg::queue_status_type q_status;
   logic refresh_busy, accept, push, pop, head_valid;

   // hold off commands while derived terms settle or the queue is nearly full
   assign busy   = refresh_busy || q_status.almost_full;
   assign accept = start && !busy;

   pcm_coef u_coef (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .coefs        (coefs),
      .derived      (derived),
      .refresh_busy (refresh_busy)
   );

   // front: products and sums, forward or closed-form inverse
   pcm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_word (req_word),
      .coefs    (coefs),
      .derived  (derived),
      .push     (push),
      .push_job (push_job)
   );

   pcm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job),
      .status     (q_status)
   );

   // back: sign handling, rounding, division, saturation
   pcm_div u_div (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_word   (rsp_word)
   );

endmodule

### design/pcm_checker.sv
// Port-level checks for the perspective coordinate map unit, bound to the top
`include "perspective_coordinate_map_unit_assert.svh"

module pcm_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_valid,
   input pcm_pkg::rsp_word_type  rsp_word,
   input logic                   csr_valid,
   input logic                   csr_ready
);

   logic zero_word, coords_clear, cmd_taken, csr_taken;

   assign zero_word    = rsp_valid && rsp_word.zero_divisor;
   assign coords_clear = (rsp_word.result_x == '0) && (rsp_word.result_y == '0);
   assign cmd_taken    = start && !busy;
   assign csr_taken    = csr_valid && csr_ready;

   // a zero divisor forces both coordinates to zero
   `PCM_ASSERT_IMPLY(a_zero_clears, clock, reset, zero_word, coords_clear)

   // every result word must have a command taken at its matching earlier edge
   `PCM_ASSERT_IMPLY(a_latency, clock, reset, rsp_valid, $past(cmd_taken, 26))

   // a csr write blocks commands while derived terms refresh
   `PCM_ASSERT_NEXT(a_csr_busy, clock, reset, csr_taken, busy)

   // coming out of reset the derived terms are still being formed
   `PCM_ASSERT_ALWAYS(a_reset_busy, clock, $past(reset), busy)

endmodule

bind perspective_coordinate_map_unit pcm_checker u_pcm_checker (.*);
